// ===== rtl/mpd_pkg.sv =====
// Package for the PS/2 mouse packet decoder: event codes, the job record
// passed from the front end to the back end, and queue sizing.
// No dependencies.
`default_nettype none
package mpd_pkg;

   // Event codes on the result channel
   typedef enum logic [1:0] {
      KIND_MOVE = 2'd0,
      KIND_DOWN = 2'd1,
      KIND_UP   = 2'd2
   } event_kind_type;

   // Button count and job queue sizing
   localparam int unsigned NUM_BUTTONS = 3;
   localparam int unsigned JOB_DEPTH   = 2;
   localparam int unsigned JOB_PTR_W   = $clog2(JOB_DEPTH);
   localparam int unsigned JOB_CNT_W   = $clog2(JOB_DEPTH + 1);

   // Byte positions inside a packet
   localparam logic [1:0] POS_BUTTONS = 2'd0;
   localparam logic [1:0] POS_X       = 2'd1;
   localparam logic [1:0] POS_Y       = 2'd2;

   // One completed packet that causes at least one event.
   // mask[0] is the move event, mask[3:1] the changed buttons 1 to 3.
   typedef struct packed {
      logic [3:0]             mask;
      logic [7:0]             dx;
      logic [7:0]             dy_raw;
      logic [NUM_BUTTONS-1:0] old_buttons;
   } job_type;

endpackage
`default_nettype wire

// ===== rtl/mpd_front.sv =====
// Front end of the PS/2 mouse packet decoder: filters aux bytes, collects
// three-byte packets, tracks button state and issues jobs.
// Depends on mpd_pkg.
`default_nettype none
module mpd_front
   import mpd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_accept,
   input  wire logic    aux_ready,
   input  wire logic [7:0] data_byte,
   output logic         job_push,
   output job_type      job
);

   logic [1:0]             pos_ff, pos_in;
   logic [7:0]             byte0_ff, byte0_in;
   logic [7:0]             byte1_ff, byte1_in;
   logic [NUM_BUTTONS-1:0] buttons_ff, buttons_in;
   logic [NUM_BUTTONS-1:0] changed;
   logic                   has_move;
   logic                   take;

   assign take     = req_accept && aux_ready;
   assign changed  = byte0_ff[NUM_BUTTONS-1:0] ^ buttons_ff;
   assign has_move = (byte1_ff != 8'd0) || (data_byte != 8'd0);

   // Build the job for a packet completed by this byte
   always_comb begin
      job.mask        = {changed, has_move};
      job.dx          = byte1_ff;
      job.dy_raw      = data_byte;
      job.old_buttons = buttons_ff;
      job_push        = take && (pos_ff == POS_Y) && (job.mask != 4'd0);
   end

   // Advance the packet position and latch packet bytes
   always_comb begin
      pos_in     = pos_ff;
      byte0_in   = byte0_ff;
      byte1_in   = byte1_ff;
      buttons_in = buttons_ff;
      if (take) begin
         case (pos_ff)
            POS_BUTTONS: begin
               byte0_in = data_byte;
               pos_in   = POS_X;
            end
            POS_X: begin
               byte1_in = data_byte;
               pos_in   = POS_Y;
            end
            POS_Y: begin
               buttons_in = byte0_ff[NUM_BUTTONS-1:0];
               pos_in     = POS_BUTTONS;
            end
            default: begin
               pos_in = POS_BUTTONS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_BUTTONS;
         buttons_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         buttons_ff <= buttons_in;
      end
   end

   // Packet bytes need no reset
   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
   end

endmodule
`default_nettype wire

// ===== rtl/mpd_job_queue.sv =====
// Short job queue between front and back end of the mouse packet decoder.
// Depends on mpd_pkg.
`default_nettype none
module mpd_job_queue
   import mpd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   output logic      full,
   input  wire logic pop,
   output logic      empty,
   output job_type   head_job
);

   job_type              slot_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [JOB_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + JOB_CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - JOB_CNT_W'(1);
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + JOB_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + JOB_PTR_W'(1);
         end
      end
   end

   // Store the job
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

// ===== rtl/mpd_back.sv =====
// Back end of the mouse packet decoder: expands one job into its move and
// button events into the result register, one per cycle unless it stalls.
// Depends on mpd_pkg.
`default_nettype none
module mpd_back
   import mpd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  job_empty,
   input  job_type    head_job,
   output logic       job_pop,
   input  wire logic  rsp_pop,
   output logic       rsp_empty,
   output logic [1:0] rsp_event_kind,
   output logic signed [7:0] rsp_move_x,
   output logic signed [8:0] rsp_move_y,
   output logic [1:0] rsp_button_number,
   output logic       rsp_last_event
);

   logic [3:0]             pend_ff, pend_in;
   logic [7:0]             dx_ff;
   logic [7:0]             dy_ff;
   logic [NUM_BUTTONS-1:0] old_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [1:0]             kind_ff, kind_in;
   logic signed [7:0]      mx_ff, mx_in;
   logic signed [8:0]      my_ff, my_in;
   logic [1:0]             btn_ff, btn_in;
   logic                   last_ff, last_in;
   logic [3:0]             sel;
   logic [3:0]             rest;
   logic                   emit;
   logic                   load;

   // Pick the lowest pending event: move first, then buttons 1 to 3
   always_comb begin
      sel = 4'd0;
      if (pend_ff[0]) sel = 4'b0001;
      else if (pend_ff[1]) sel = 4'b0010;
      else if (pend_ff[2]) sel = 4'b0100;
      else if (pend_ff[3]) sel = 4'b1000;
   end

   assign rest    = pend_ff & ~sel;
   assign emit    = (pend_ff != 4'd0) && (!out_valid_ff || rsp_pop);
   assign load    = (pend_ff == 4'd0) || (emit && (rest == 4'd0));
   assign job_pop = load && !job_empty;

   // Form the next event and hold the result register while stalled
   always_comb begin
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      kind_in      = kind_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      btn_in       = btn_ff;
      last_in      = last_ff;
      if (emit) begin
         pend_in      = rest;
         out_valid_in = 1'b1;
         last_in      = (rest == 4'd0);
         mx_in        = '0;
         my_in        = '0;
         kind_in      = KIND_MOVE;
         btn_in       = 2'd0;
         case (sel)
            4'b0001: begin
               mx_in = $signed(dx_ff);
               my_in = $signed(9'd0 - {dy_ff[7], dy_ff});
            end
            4'b0010: begin
               kind_in = old_ff[0] ? KIND_UP : KIND_DOWN;
               btn_in  = 2'd1;
            end
            4'b0100: begin
               kind_in = old_ff[1] ? KIND_UP : KIND_DOWN;
               btn_in  = 2'd2;
            end
            4'b1000: begin
               kind_in = old_ff[2] ? KIND_UP : KIND_DOWN;
               btn_in  = 2'd3;
            end
            default: begin
               btn_in = 2'd0;
            end
         endcase
      end
      if (job_pop) pend_in = head_job.mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Job payload and result payload need no reset
   always_ff @(posedge clock) begin
      if (job_pop) begin
         dx_ff  <= head_job.dx;
         dy_ff  <= head_job.dy_raw;
         old_ff <= head_job.old_buttons;
      end
      kind_ff <= kind_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      btn_ff  <= btn_in;
      last_ff <= last_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_move_x        = mx_ff;
   assign rsp_move_y        = my_ff;
   assign rsp_button_number = btn_ff;
   assign rsp_last_event    = last_ff;

endmodule
`default_nettype wire

// ===== rtl/ps2_mouse_packet_decoder_core.sv =====
// Top level of the PS/2 mouse packet decoder.
// Depends on mpd_pkg, mpd_front, mpd_job_queue and mpd_back.
//
// Each request is one controller byte with its aux flag; bytes without the
// flag are dropped. Every third aux byte completes a packet, which yields a
// move event (when either motion byte is nonzero) and then one press or
// release event per changed button, 1 to 3, with the final event flagged.
// A request is taken whenever the job queue is not full; a packet's events
// leave the single event register in the back end at one per cycle while
// the result side pops them. Up to two completed packets wait in the job
// queue between front and back end, so requests keep flowing while results
// are stalled until that queue fills.
`default_nettype none
module ps2_mouse_packet_decoder_core
   import mpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_aux_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_event_kind,
   output logic signed [7:0] rsp_move_x,
   output logic signed [8:0] rsp_move_y,
   output logic [1:0]       rsp_button_number,
   output logic             rsp_last_event
);

   logic    job_push;
   job_type job_in;
   logic    q_full;
   logic    q_empty;
   logic    job_pop;
   job_type head_job;

   assign req_full = q_full;

   mpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_push && !q_full),
      .aux_ready  (req_aux_ready),
      .data_byte  (req_data_byte),
      .job_push   (job_push),
      .job        (job_in)
   );

   mpd_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .full     (q_full),
      .pop      (job_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   mpd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_empty         (q_empty),
      .head_job          (head_job),
      .job_pop           (job_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_move_x        (rsp_move_x),
      .rsp_move_y        (rsp_move_y),
      .rsp_button_number (rsp_button_number),
      .rsp_last_event    (rsp_last_event)
   );

endmodule
`default_nettype wire
